>>> rtl/tone_step_queue_player_macros.svh
// assertion macros for the tone step queue player checker
// used by tsqp_checker only; no other dependencies
`ifndef TONE_STEP_QUEUE_PLAYER_MACROS_SVH
`define TONE_STEP_QUEUE_PLAYER_MACROS_SVH

// property sampled on the rising clock edge, ignored while reset is active
`define TSQP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property sampled on the rising clock edge, also checked during reset
`define TSQP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tsqp_pkg.sv
// shared types and codes for the tone step queue player
// no dependencies; imported by every module of the block but tsqp_checker
package tsqp_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_ATTACH  = 2'd1;
    localparam logic [1:0] REQ_TONE    = 2'd2;
    localparam logic [1:0] REQ_PATTERN = 2'd3;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;
    localparam int RESULT_W   = 27;

    // one queued step, frequency in the upper half
    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
    } step_t;

    // result transaction, last field in the lowest bit
    typedef struct packed {
        logic        busy;
        logic [3:0]  level;
        logic        dropped;
        logic [3:0]  accepted;
        logic [15:0] freq;
        logic        changed;
    } result_t;

endpackage

>>> rtl/tsqp_step_ram.sv
// step store of the tone step queue player: one write port, one read port
// read data registered; uses tsqp_pkg for the step type
module tsqp_step_ram
    import tsqp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    localparam int PW = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [PW-1:0] wr_addr,
    input  step_t         wr_data,
    input  logic          rd_en,
    input  logic [PW-1:0] rd_addr,
    output step_t         rd_data
);

    step_t mem [QUEUE_DEPTH];
    step_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tsqp_ctrl.sv
// request sequencer of the tone step queue player: queue pointers, player state,
// output register; drives the step store in tsqp_step_ram, uses tsqp_pkg
module tsqp_ctrl
    import tsqp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    localparam int PW = $clog2(QUEUE_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  wr_en,
    output logic [PW-1:0]         wr_addr,
    output step_t                 wr_data,
    output logic                  rd_en,
    output logic [PW-1:0]         rd_addr,
    input  step_t                 rd_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUT  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

    // control state
    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic          playing_reg, playing_next;
    logic [31:0]   end_time_reg, end_time_next;
    logic          attached_reg, attached_next;
    logic [15:0]   cur_freq_reg, cur_freq_next;
    logic          out_valid_reg, out_valid_next;
    logic          pause_next_reg, pause_next_next;

    // per-request working registers
    logic [31:0]   now_reg, now_next;
    logic [15:0]   freq_reg, freq_next;
    logic [15:0]   dur_reg, dur_next;
    logic [15:0]   pause_reg, pause_next;
    logic [7:0]    tones_left_reg, tones_left_next;
    logic          changed_reg, changed_next;
    logic [3:0]    acc_reg, acc_next;
    logic          drop_reg, drop_next;
    result_t       out_data_reg, out_data_next;

    // request fields
    logic [31:0] in_now;
    logic [15:0] in_freq;
    logic [15:0] in_dur;
    logic [15:0] in_pause;
    logic [7:0]  in_count;
    logic [31:0] end_diff;
    logic [PW-1:0] level_cur;
    logic          fin;
    logic          go;
    logic          out_free;

    assign in_now   = s_tdata[31:0];
    assign in_freq  = s_tdata[47:32];
    assign in_dur   = s_tdata[63:48];
    assign in_pause = s_tdata[79:64];
    assign in_count = s_tdata[87:80];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - RESULT_W)'(0), out_data_reg};

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == LAST_IDX)
        begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] fifo_level(input logic [PW-1:0] wp,
                                                 input logic [PW-1:0] rp);
        logic [PW:0] d;
        if (wp >= rp)
        begin
            d = {1'b0, wp} - {1'b0, rp};
        end
        else
        begin
            d = {1'b0, wp} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rp};
        end
        return d[PW-1:0];
    endfunction

    function automatic logic [3:0] sat15(input logic [PW-1:0] v);
        logic [8:0] w;
        w = 9'(v);
        if (w > 9'd15)
        begin
            return 4'hF;
        end
        return w[3:0];
    endfunction

    assign end_diff  = in_now - end_time_reg;
    assign level_cur = fifo_level(wp_reg, rp_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        playing_next    = playing_reg;
        end_time_next   = end_time_reg;
        attached_next   = attached_reg;
        cur_freq_next   = cur_freq_reg;
        out_valid_next  = out_valid_reg;
        pause_next_next = pause_next_reg;
        now_next        = now_reg;
        freq_next       = freq_reg;
        dur_next        = dur_reg;
        pause_next      = pause_reg;
        tones_left_next = tones_left_reg;
        changed_next    = changed_reg;
        acc_next        = acc_reg;
        drop_next       = drop_reg;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = wp_reg;
        wr_data         = pause_next_reg ? {16'd0, pause_reg} : {freq_reg, dur_reg};
        rd_en           = 1'b0;
        rd_addr         = rp_reg;
        fin             = 1'b0;
        go              = 1'b1;

        // result taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next     = in_now;
                    freq_next    = in_freq;
                    dur_next     = in_dur;
                    pause_next   = in_pause;
                    changed_next = 1'b0;
                    acc_next     = 4'd0;
                    drop_next    = 1'b0;
                    case (s_tuser)
                        REQ_TICK:
                        begin
                            if (attached_reg)
                            begin
                                // current step ends once the signed difference is not negative
                                if (playing_reg)
                                begin
                                    if (end_diff[31])
                                    begin
                                        go = 1'b0;
                                    end
                                    else
                                    begin
                                        cur_freq_next = 16'd0;
                                        changed_next  = 1'b1;
                                        playing_next  = 1'b0;
                                    end
                                end
                                if (go && (rp_reg != wp_reg))
                                begin
                                    rd_en      = 1'b1;
                                    state_next = ST_TICK;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        REQ_ATTACH:
                        begin
                            attached_next = 1'b1;
                            cur_freq_next = 16'd0;
                            changed_next  = 1'b1;
                            fin           = 1'b1;
                        end
                        REQ_TONE:
                        begin
                            attached_next = 1'b1;
                            if (in_dur != 16'd0)
                            begin
                                tones_left_next = 8'd1;
                                pause_next_next = 1'b0;
                                state_next      = ST_PUT;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        REQ_PATTERN:
                        begin
                            if (attached_reg && (in_count != 8'd0) && (in_dur != 16'd0))
                            begin
                                tones_left_next = in_count;
                                pause_next_next = 1'b0;
                                state_next      = ST_PUT;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                // queue full: every remaining step is dropped as well
                if (level_cur == LAST_IDX)
                begin
                    drop_next = 1'b1;
                    fin       = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wp_next  = ptr_inc(wp_reg);
                    acc_next = (acc_reg == 4'hF) ? 4'hF : acc_reg + 4'd1;
                    if (pause_next_reg)
                    begin
                        pause_next_next = 1'b0;
                    end
                    else
                    begin
                        tones_left_next = tones_left_reg - 8'd1;
                        pause_next_next = (pause_reg != 16'd0) && (tones_left_reg != 8'd1);
                        if (tones_left_reg == 8'd1)
                        begin
                            fin = 1'b1;
                        end
                    end
                end
            end
            ST_TICK:
            begin
                // start the step just read from the store
                cur_freq_next = rd_data.freq;
                changed_next  = 1'b1;
                end_time_next = now_reg + 32'(rd_data.dur);
                playing_next  = 1'b1;
                rp_next       = ptr_inc(rp_reg);
                fin           = 1'b1;
            end
            ST_HOLD:
            begin
                fin = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the result to the output register or wait for room
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next         = 1'b1;
                out_data_next.changed  = changed_next;
                out_data_next.freq     = cur_freq_next;
                out_data_next.accepted = acc_next;
                out_data_next.dropped  = drop_next;
                out_data_next.level    = sat15(fifo_level(wp_next, rp_next));
                out_data_next.busy     = playing_next;
                state_next             = ST_IDLE;
            end
            else
            begin
                state_next = ST_HOLD;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            playing_reg    <= 1'b0;
            end_time_reg   <= 32'd0;
            attached_reg   <= 1'b0;
            cur_freq_reg   <= 16'd0;
            out_valid_reg  <= 1'b0;
            pause_next_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            playing_reg    <= playing_next;
            end_time_reg   <= end_time_next;
            attached_reg   <= attached_next;
            cur_freq_reg   <= cur_freq_next;
            out_valid_reg  <= out_valid_next;
            pause_next_reg <= pause_next_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        freq_reg       <= freq_next;
        dur_reg        <= dur_next;
        pause_reg      <= pause_next;
        tones_left_reg <= tones_left_next;
        changed_reg    <= changed_next;
        acc_reg        <= acc_next;
        drop_reg       <= drop_next;
        out_data_reg   <= out_data_next;
    end

endmodule

>>> rtl/tone_step_queue_player.sv
// Tone step queue player: requests enter as one transaction each and every request
// returns one result transaction. An attach request, a tick that starts no step and a
// request that enqueues nothing finish in the idle state. A tick that starts a queued
// step reads it from the step store, whose read data is registered, and starts it in the
// tick state. A tone or pattern request writes its steps in the put state and drops the
// rest once the queue is full; the store writes one step per cycle through its single
// write port. A new request is taken while the previous result still waits in the output
// register; a result that finds it occupied waits in the sequencer's hold state, with no
// request taken, until it is free. The queue holds at most QUEUE_DEPTH - 1 steps.
// Top level; instantiates tsqp_ctrl and tsqp_step_ram, uses tsqp_pkg.
module tone_step_queue_player
    import tsqp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], freq_hz[47:32], duration_ms[63:48], pause_ms[79:64],
    // repeat_count[87:80]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tone_changed[0], tone_freq_hz[16:1], accepted_steps[20:17], steps_dropped[21],
    // queue_level[25:22], busy_res[26], zero fill[31:27]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic          wr_en;
    logic [PW-1:0] wr_addr;
    step_t         wr_data;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    step_t         rd_data;

    // request sequencer and player state
    tsqp_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // step store
    tsqp_step_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_step_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> rtl/tsqp_checker.sv
// port-level checks for the tone step queue player, bound to the top level
// uses the assertion macros of tone_step_queue_player_macros.svh
`include "tone_step_queue_player_macros.svh"

module tsqp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // no result transaction offered once reset has been seen
    `TSQP_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !m_tvalid, "result valid during reset")

    // a stalled result stays offered and unchanged
    `TSQP_ASSERT(a_out_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled result changed")

    // an idle player always drives silence
    `TSQP_ASSERT(a_idle_silent,
        m_tvalid && !m_tdata[26] |-> m_tdata[16:1] == 16'd0,
        "idle player with nonzero frequency")

    // only ticks and attaches rewrite the frequency, and they enqueue nothing
    `TSQP_ASSERT(a_change_no_enq,
        m_tvalid && m_tdata[0] |-> m_tdata[20:17] == 4'd0 && !m_tdata[21],
        "frequency change with enqueue report")

endmodule

bind tone_step_queue_player tsqp_checker u_tsqp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tone_step_queue_player_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tone_step_queue_player: a directed table, then random requests.
// Each result is checked against its typed row or a behavioral predictor. Depends on tsqp_pkg.
module tone_step_queue_player_tb
    import tsqp_pkg::*;
();

    localparam int QD         = 16;
    localparam int RAND_ITEMS = 220;

    // one request transaction as the block sees it
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [15:0] freq;
        logic [15:0] dur;
        logic [15:0] pause;
        logic [7:0]  count;
    } tone_req_t;

    // directed row; want is used only when typed is set
    typedef struct packed {
        tone_req_t req;
        logic      typed;
        result_t   want;
    } vec_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = REQ_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // predictor state
    step_t       queued_steps [QD];
    int          q_rd = 0;
    int          q_wr = 0;
    bit          is_playing = 1'b0;
    bit          is_attached = 1'b0;
    logic [31:0] step_end_ms = '0;
    logic [15:0] drive_freq = '0;

    result_t     owed_results [$];
    vec_row_t    directed_rows [$];
    int          mismatch_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic [31:0] wall_ms = '0;

    tone_step_queue_player #(.QUEUE_DEPTH(QD)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int queue_fill();
        return (q_wr + QD - q_rd) % QD;
    endfunction

    function automatic bit push_step(input logic [15:0] f, input logic [15:0] d);
        if (queue_fill() >= QD - 1)
            return 1'b0;
        queued_steps[q_wr] = '{freq: f, dur: d};
        q_wr = (q_wr + 1) % QD;
        return 1'b1;
    endfunction

    // advance the predictor by one request and return the result it owes
    function automatic result_t play_request(input tone_req_t r);
        result_t     res;
        logic [31:0] diff;
        step_t       nxt;
        bit          go;
        int          acc;
        int          fill;
        res = '0;
        acc = 0;
        case (r.kind)
            REQ_TICK:
            begin
                if (is_attached)
                begin
                    go = 1'b1;
                    // current step ends once the signed distance to its end time is not negative
                    if (is_playing)
                    begin
                        diff = r.now_ms - step_end_ms;
                        if (diff[31])
                            go = 1'b0;
                        else
                        begin
                            drive_freq  = '0;
                            res.changed = 1'b1;
                            is_playing  = 1'b0;
                        end
                    end
                    if (go && q_rd != q_wr)
                    begin
                        nxt         = queued_steps[q_rd];
                        q_rd        = (q_rd + 1) % QD;
                        drive_freq  = nxt.freq;
                        res.changed = 1'b1;
                        step_end_ms = r.now_ms + 32'(nxt.dur);
                        is_playing  = 1'b1;
                    end
                end
            end
            REQ_ATTACH:
            begin
                is_attached = 1'b1;
                drive_freq  = '0;
                res.changed = 1'b1;
            end
            REQ_TONE:
            begin
                is_attached = 1'b1;
                if (r.dur != 0)
                begin
                    if (push_step(r.freq, r.dur))
                        acc = 1;
                    else
                        res.dropped = 1'b1;
                end
            end
            default:
            begin
                // tones with optional silent gaps between them
                if (is_attached && r.count != 0 && r.dur != 0)
                begin
                    for (int i = 0; i < int'(r.count); i++)
                    begin
                        if (push_step(r.freq, r.dur))
                            acc++;
                        else
                            res.dropped = 1'b1;
                        if (i + 1 < int'(r.count) && r.pause != 0)
                        begin
                            if (push_step(16'd0, r.pause))
                                acc++;
                            else
                                res.dropped = 1'b1;
                        end
                    end
                end
            end
        endcase
        fill         = queue_fill();
        res.freq     = drive_freq;
        res.accepted = (acc > 15) ? 4'd15 : 4'(acc);
        res.level    = (fill > 15) ? 4'd15 : 4'(fill);
        res.busy     = is_playing;
        return res;
    endfunction

    function automatic void add_row(input logic [1:0] kind, input logic [31:0] now_ms,
                                    input logic [15:0] freq, input logic [15:0] dur,
                                    input logic [15:0] pause, input logic [7:0] count,
                                    input int typed, input logic chg, input logic [15:0] fq,
                                    input int acc, input int drp,
                                    input int lvl, input int busy);
        vec_row_t row;
        row.req   = '{kind: kind, now_ms: now_ms, freq: freq, dur: dur, pause: pause,
                      count: count};
        row.typed = 1'(typed);
        row.want  = '{busy: 1'(busy), level: 4'(lvl), dropped: 1'(drp), accepted: 4'(acc),
                      freq: fq, changed: chg};
        directed_rows.push_back(row);
    endfunction

    function automatic logic [15:0] pick_len();
        int p;
        p = $urandom_range(99);
        if (p < 8)
            return 16'd0;
        else if (p < 18)
            return 16'($urandom());
        return 16'($urandom_range(30, 1));
    endfunction

    // half ticks on a mostly slowly advancing clock, mixed with tone, pattern and attach requests
    function automatic tone_req_t random_request();
        tone_req_t r;
        int        p;
        r.now_ms = $urandom();
        r.freq   = 16'($urandom());
        r.dur    = pick_len();
        r.pause  = pick_len();
        r.count  = 8'($urandom_range(4, 1));
        if ($urandom_range(9) == 0)
            r.count = 8'($urandom());
        p = $urandom_range(99);
        if (p < 50)
        begin
            r.kind = REQ_TICK;
            if ($urandom_range(19) == 0)
                wall_ms = $urandom();
            else
                wall_ms = wall_ms + 32'($urandom_range(40));
            r.now_ms = wall_ms;
        end
        else if (p < 75)
            r.kind = REQ_TONE;
        else if (p < 92)
            r.kind = REQ_PATTERN;
        else if (p < 96)
            r.kind = REQ_ATTACH;
        else
            r.kind = 2'($urandom());
        return r;
    endfunction

    // drive one request transaction, then record what it owes once accepted
    task automatic send_item(input tone_req_t r, input logic typed, input result_t want);
        result_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {r.count, r.pause, r.dur, r.freq, r.now_ms};
        do
            @(posedge clk);
        while (!s_tready);
        pred = play_request(r);
        owed_results.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // compare each result transaction with the oldest owed result
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RESULT_W-1:0];
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %0h",
                         $time, got);
                mismatch_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("tone_changed", 32'(want.changed), 32'(got.changed));
                check_field("tone_freq_hz", 32'(want.freq), 32'(got.freq));
                check_field("accepted_steps", 32'(want.accepted), 32'(got.accepted));
                check_field("steps_dropped", 32'(want.dropped), 32'(got.dropped));
                check_field("queue_level", 32'(want.level), 32'(got.level));
                check_field("busy_res", 32'(want.busy), 32'(got.busy));
            end
        end
    end

    // stimulus
    initial
    begin
        //      kind         now_ms        freq      dur       pause     cnt
        //      t  chg   freq      acc drp lvl bsy
        add_row(REQ_TICK,    32'h0,        16'h0,    16'h0,    16'h0,    8'd0,
                1, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_PATTERN, 32'h0,        16'h1234, 16'd10,   16'd5,    8'd3,
                1, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_ATTACH,  32'h0,        16'h0,    16'h0,    16'h0,    8'd0,
                1, 1'b1, 16'h0,    0,  0,  0,  0);
        add_row(REQ_TONE,    32'h0,        16'hFFFF, 16'h0,    16'h0,    8'd0,
                1, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_TONE,    32'h0,        16'hFFFF, 16'hFFFF, 16'h0,    8'd0,
                1, 1'b0, 16'h0,    1,  0,  1,  0);
        add_row(REQ_TICK,    32'h0,        16'h0,    16'h0,    16'h0,    8'd0,
                1, 1'b1, 16'hFFFF, 0,  0,  0,  1);
        // one before the end time: still playing
        add_row(REQ_TICK,    32'hFFFE,     16'h0,    16'h0,    16'h0,    8'd0,
                1, 1'b0, 16'hFFFF, 0,  0,  0,  1);
        add_row(REQ_TICK,    32'hFFFF,     16'h0,    16'h0,    16'h0,    8'd0,
                1, 1'b1, 16'h0,    0,  0,  0,  0);
        // oversized pattern fills the queue and drops the rest
        add_row(REQ_PATTERN, 32'h0,        16'h8001, 16'd1,    16'd1,    8'd255,
                1, 1'b0, 16'h0,    15, 1,  15, 0);
        add_row(REQ_TONE,    32'h0,        16'd5,    16'd5,    16'h0,    8'd0,
                1, 1'b0, 16'h0,    0,  1,  15, 0);
        add_row(REQ_PATTERN, 32'h0,        16'd7,    16'd5,    16'd1,    8'd0,
                1, 1'b0, 16'h0,    0,  0,  15, 0);
        add_row(REQ_PATTERN, 32'h0,        16'd7,    16'd0,    16'd1,    8'd5,
                1, 1'b0, 16'h0,    0,  0,  15, 0);
        // end time wraps past zero
        add_row(REQ_TICK,    32'hFFFFFFFF, 16'h0,    16'h0,    16'h0,    8'd0,
                1, 1'b1, 16'h8001, 0,  0,  14, 1);
        add_row(REQ_TICK,    32'h0,        16'h0,    16'h0,    16'h0,    8'd0,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_TICK,    32'h80000000, 16'h0,    16'h0,    16'h0,    8'd0,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        // difference of exactly half the range counts as not yet ended
        add_row(REQ_TICK,    32'h1,        16'h0,    16'h0,    16'h0,    8'd0,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_ATTACH,  32'h0,        16'h0,    16'h0,    16'h0,    8'd0,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_TICK,    32'h80000001, 16'h0,    16'h0,    16'h0,    8'd0,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_PATTERN, 32'h0,        16'h7FFE, 16'd2,    16'h0,    8'd2,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_TONE,    32'h0,        16'h0,    16'd3,    16'h0,    8'd0,
                0, 1'b0, 16'h0,    0,  0,  0,  0);
        add_row(REQ_PATTERN, 32'h0,        16'hAAAA, 16'h5555, 16'hFFFF, 8'd2,
                0, 1'b0, 16'h0,    0,  0,  0,  0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // random phases with different idle and stall mixes, draining between them
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 25 : 0;
            stall_pct = (ph == 2) ? 47 : (ph == 3) ? 25 : 0;
            for (int n = 0; n < RAND_ITEMS; n++)
                send_item(random_request(), 1'b0, '0);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("tone_step_queue_player verification clean");
        else
            $display("tone_step_queue_player verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tone_step_queue_player verification failed");
        $finish;
    end

endmodule
